// ----- rtl/core/tdpt_pkg.sv -----
// Shared types and constants of the trial-division prime tester.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  localparam int unsigned ENTRY_WIDTH       = 14;
  localparam int unsigned TABLE_DEPTH_DEF   = 2048;
  localparam int unsigned CAND_WIDTH_DEF    = 27;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } tdpt_state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpt_div_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdpt_if.sv -----
// Request and response channel interfaces of the trial-division prime tester.
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_req_if
  import tdpt_pkg::*;
#(
  parameter int unsigned CAND_W = CAND_WIDTH_DEF
) ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CAND_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface tdpt_rsp_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, prime_flag, input ready);
  modport sink   (input valid, prime_flag, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tdpt_rem.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_rem
  import tdpt_pkg::*;
#(
  parameter int unsigned CAND_W = CAND_WIDTH_DEF,
  parameter int unsigned DIV_W  = ENTRY_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CAND_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0]  divisor_i,
  output tdpt_div_sts_t          sts_o
);

  localparam int unsigned CNT_W = $clog2(CAND_W + 1);

  logic [CAND_W-1:0] shift_q;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;
  logic [DIV_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem_q, shift_q[CAND_W-1]};
    diff     = trial - {1'b0, div_q};
    fits     = trial >= {1'b0, div_q};
    // remainder stays below the divisor, so the top bit drops either way
    rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(CAND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      div_q   <= divisor_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[CAND_W-2:0], 1'b0};
      rem_q   <= rem_next;
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/trial_division_prime_test.sv -----
// Top level of the trial-division prime tester with its prime table memory.
//
// Usage: one request channel (req_i) and one response channel (rsp_o),
// both valid/ready. A request with mode = load appends the low 14 bits of
// value to the prime table (ascending primes expected) and gives no
// response; loads after the table holds TABLE_DEPTH entries are dropped.
// A request with mode = test gives one response, prime_flag for value.
// A load is written as it is accepted and the block stays idle, so the
// next request can be taken in the following cycle. A test of a
// candidate below 2 goes straight to the done state, which loads the
// response register. Otherwise each empty table entry passes the fetch
// and evaluate states, and each other visited entry the fetch, evaluate
// and compare states for the memory read, the square and the compare,
// plus a run of the bit-serial remainder unit when the square does not
// yet exceed the candidate; that unit sets the rate of tests.
// One request is worked on at a time. The response sits in an output
// register; while the receiver stalls it, the next request is still
// accepted and worked on, and its response waits until the register frees.
// Reset empties the table (the count returns to zero, the memory itself
// is not cleared) and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEF,
  parameter int unsigned CANDIDATE_WIDTH = CAND_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tdpt_req_if.sink    req_i,
  tdpt_rsp_if.source  rsp_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SQ_W   = 2 * ENTRY_WIDTH;
  localparam int unsigned CMP_W  = (SQ_W > CANDIDATE_WIDTH) ? SQ_W : CANDIDATE_WIDTH;

  // prime table, synchronous read into a registered output
  logic [ENTRY_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_q;

  tdpt_state_e                state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic [CANDIDATE_WIDTH-1:0] cand_q, cand_d;
  logic [SQ_W-1:0]            sq_q, sq_d;
  logic                       res_q, res_d;
  logic                       out_valid_q, out_valid_d;
  logic                       prime_flag_q, prime_flag_d;

  logic                       mem_we;
  logic                       rd_en;
  logic                       div_start;
  tdpt_div_sts_t              div_sts;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cand_q       <= cand_d;
    sq_q         <= sq_d;
    res_q        <= res_d;
    prime_flag_q <= prime_flag_d;
  end

  // table memory: write on load, read on fetch
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[ADDR_W-1:0]] <= ENTRY_WIDTH'(req_i.value);
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[ADDR_W-1:0]];
    end
  end

  tdpt_rem #(
    .CAND_W (CANDIDATE_WIDTH),
    .DIV_W  (ENTRY_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (rd_q),
    .sts_o      (div_sts)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cand_d       = cand_q;
    sq_d         = sq_q;
    res_d        = res_q;
    prime_flag_d = prime_flag_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    req_i.ready  = 1'b0;

    // response register drains whenever the receiver takes it
    out_valid_d = out_valid_q && !rsp_o.ready;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.mode == MODE_LOAD) begin
            if (count_q != CNT_W'(TABLE_DEPTH)) begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end else begin
            cand_d = req_i.value;
            idx_d  = '0;
            if (req_i.value < CANDIDATE_WIDTH'(2)) begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              state_d = ST_FETCH;
            end
          end
        end
      end

      ST_FETCH: begin
        if (idx_q == count_q) begin
          // walked off the filled part of the table
          res_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (rd_q == '0) begin
          // empty entry: skip it
          idx_d   = idx_q + CNT_W'(1);
          state_d = ST_FETCH;
        end else begin
          sq_d    = SQ_W'(rd_q) * SQ_W'(rd_q);
          state_d = ST_CMP;
        end
      end

      ST_CMP: begin
        if (CMP_W'(sq_q) > CMP_W'(cand_q)) begin
          res_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = ST_FETCH;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          prime_flag_d = res_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.prime_flag = prime_flag_q;

endmodule

`default_nettype wire

// ----- rtl/core/tdpt_checker.sv -----
// Port-level assertions for the prime tester, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_checker
  import tdpt_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic req_mode_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire logic rsp_prime_flag_i
);

  // a stalled response keeps its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_prime_flag_i))
    else $error("stalled response changed");

  // a load request never produces a response
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_mode_i == MODE_LOAD |=> !$rose(rsp_valid_i))
    else $error("response raised after a load request");

  // a test request keeps the block busy in the cycle after it is taken
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_mode_i == MODE_TEST |=> !req_ready_i)
    else $error("request taken right after a test request");

  // a fresh response only comes out of a busy phase
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("response raised while the block was idle");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_mode_i       (req_i.mode),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_prime_flag_i (rsp_o.prime_flag)
);

`default_nettype wire
